[rtl/assert_macros.svh]
// Assertion helpers for the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (expr)) else $error(msg);

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLY(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/acps_pkg.sv]
package acps_pkg;

  localparam int LBA_W       = 28;
  localparam int POLL_W      = 16;
  localparam int MAX_CHUNK   = 256;
  localparam int CHUNK_W     = $clog2(MAX_CHUNK) + 1;
  localparam int WORDS_W     = CHUNK_W + 8;
  localparam int STAT_W      = 8;

  localparam int IN_DATA_W   = 72;
  localparam int OUT_DATA_W  = 32;
  localparam int TYPE_W      = 3;
  localparam int CFG_IDX_W   = 1;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Request kinds
  localparam logic [TYPE_W-1:0] REQ_START = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_IRQ   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_STAT  = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_TICK  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_XDONE = 3'd4;

  // Result actions
  localparam logic [2:0] ACT_REG      = 3'd0;
  localparam logic [2:0] ACT_STATUS   = 3'd1;
  localparam logic [2:0] ACT_XFER     = 3'd2;
  localparam logic [2:0] ACT_DONE     = 3'd3;
  localparam logic [2:0] ACT_NOTREADY = 3'd4;
  localparam logic [2:0] ACT_TIMEOUT  = 3'd5;
  localparam logic [2:0] ACT_REJECT   = 3'd6;

  // Task-file offsets
  localparam logic [2:0] TF_COUNT  = 3'd2;
  localparam logic [2:0] TF_LBA_LO = 3'd3;
  localparam logic [2:0] TF_LBA_MD = 3'd4;
  localparam logic [2:0] TF_LBA_HI = 3'd5;
  localparam logic [2:0] TF_DEVICE = 3'd6;
  localparam logic [2:0] TF_CMD    = 3'd7;

  localparam logic [7:0] ST_BSY    = 8'h80;
  localparam logic [7:0] ST_DRQ    = 8'h08;
  localparam logic [7:0] DEV_BASE  = 8'hA0;
  localparam logic [7:0] DEV_LBA   = 8'h40;
  localparam logic [7:0] DEV_SLAVE = 8'h10;
  localparam logic [7:0] CMD_RD    = 8'h20;
  localparam logic [7:0] CMD_WR    = 8'h30;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGHEST_LBA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT  = 1'd1;

  localparam logic [LBA_W-1:0]  HIGHEST_LBA_RST = 28'd163839;
  localparam logic [POLL_W-1:0] POLL_LIMIT_RST  = 16'd3000;

  typedef struct packed {
    logic [LBA_W-1:0]  highest_lba;
    logic [POLL_W-1:0] poll_limit;
  } cfg_t;

  // One unit of back-end work: either a single result or a command sequence
  typedef struct packed {
    logic               cmd;
    logic               sel;
    logic [2:0]         action;
    logic [7:0]         count;
    logic [LBA_W-1:0]   lba;
    logic [7:0]         dev;
    logic [7:0]         opcode;
    logic [WORDS_W-1:0] words;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

endpackage

[rtl/acps_front.sv]
module acps_front (
  input  logic                           clk,
  input  logic                           rst,
  input  acps_pkg::cfg_t                 cfg,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [acps_pkg::TYPE_W-1:0]    in_type,
  input  logic [acps_pkg::IN_DATA_W-1:0] in_data,
  input  acps_pkg::q_stat_t              q_stat,
  output logic                           push,
  output acps_pkg::job_t                 job
);
  import acps_pkg::*;

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_WAIT_RD = 3'd1;
  localparam logic [2:0] PH_POLL    = 3'd2;
  localparam logic [2:0] PH_XFER    = 3'd3;
  localparam logic [2:0] PH_WAIT_WR = 3'd4;

  logic [2:0]         phase, phase_next;
  logic               write_mode, write_mode_next;
  logic               drive_bit, drive_bit_next;
  logic [LBA_W-1:0]   next_lba, next_lba_next;
  logic [LBA_W-1:0]   sectors_left, sectors_left_next;
  logic [CHUNK_W-1:0] chunk_sectors, chunk_sectors_next;
  logic [POLL_W-1:0]  poll_count, poll_count_next;
  logic               expecting, expecting_next;

  logic               in_wr, in_drv;
  logic [LBA_W-1:0]   in_lba, in_cnt;
  logic [STAT_W-1:0]  in_stat;
  logic               accept;

  logic [LBA_W-1:0]   fin_lba, fin_left;
  logic               do_finish, do_issue, issue_sel;
  logic [LBA_W-1:0]   iss_left, iss_lba;
  logic [CHUNK_W-1:0] iss_chunk;

  assign in_wr   = in_data[0];
  assign in_drv  = in_data[1];
  assign in_lba  = in_data[2 +: LBA_W];
  assign in_cnt  = in_data[2 + LBA_W +: LBA_W];
  assign in_stat = in_data[2 + 2*LBA_W +: STAT_W];

  assign in_ready = !q_stat.full;
  assign accept   = in_valid && in_ready;

  assign fin_lba  = next_lba + LBA_W'(chunk_sectors);
  assign fin_left = (LBA_W'(chunk_sectors) >= sectors_left) ? '0
                  : sectors_left - LBA_W'(chunk_sectors);

  always_comb begin
    phase_next         = phase;
    write_mode_next    = write_mode;
    drive_bit_next     = drive_bit;
    next_lba_next      = next_lba;
    sectors_left_next  = sectors_left;
    chunk_sectors_next = chunk_sectors;
    poll_count_next    = poll_count;
    expecting_next     = expecting;
    push               = 1'b0;
    job                = '0;
    do_finish          = 1'b0;
    do_issue           = 1'b0;
    issue_sel          = 1'b0;
    iss_left           = in_cnt;
    iss_lba            = in_lba;
    iss_chunk          = '0;

    if (accept) begin
      case (in_type)
        REQ_START: begin
          if (phase != PH_IDLE || in_cnt == '0 || in_lba > cfg.highest_lba) begin
            push       = 1'b1;
            job.action = ACT_REJECT;
          end else begin
            write_mode_next   = in_wr;
            drive_bit_next    = in_drv;
            next_lba_next     = in_lba;
            sectors_left_next = in_cnt;
            do_issue          = 1'b1;
            issue_sel         = 1'b1;
          end
        end
        REQ_IRQ: begin
          if (expecting && phase == PH_WAIT_RD) begin
            expecting_next  = 1'b0;
            poll_count_next = POLL_W'(1);
            phase_next      = PH_POLL;
            push            = 1'b1;
            job.action      = ACT_STATUS;
          end else if (expecting && phase == PH_WAIT_WR) begin
            expecting_next = 1'b0;
            do_finish      = 1'b1;
          end
        end
        REQ_STAT: begin
          if (phase == PH_POLL && (in_stat & ST_BSY) == '0) begin
            push = 1'b1;
            if ((in_stat & ST_DRQ) != '0) begin
              phase_next = PH_XFER;
              job.action = ACT_XFER;
              job.words  = {chunk_sectors, 8'h00};
            end else begin
              phase_next         = PH_IDLE;
              expecting_next     = 1'b0;
              sectors_left_next  = '0;
              chunk_sectors_next = '0;
              poll_count_next    = '0;
              job.action         = ACT_NOTREADY;
            end
          end
        end
        REQ_TICK: begin
          if (phase == PH_POLL) begin
            push = 1'b1;
            if (poll_count >= cfg.poll_limit) begin
              phase_next         = PH_IDLE;
              expecting_next     = 1'b0;
              sectors_left_next  = '0;
              chunk_sectors_next = '0;
              poll_count_next    = '0;
              job.action         = ACT_TIMEOUT;
            end else begin
              poll_count_next = poll_count + POLL_W'(1);
              job.action      = ACT_STATUS;
            end
          end
        end
        REQ_XDONE: begin
          if (phase == PH_XFER) begin
            if (write_mode) phase_next = PH_WAIT_WR;
            else do_finish = 1'b1;
          end
        end
        default: ;
      endcase
    end

    if (do_finish) begin
      next_lba_next     = fin_lba;
      sectors_left_next = fin_left;
      if (fin_left == '0) begin
        phase_next         = PH_IDLE;
        expecting_next     = 1'b0;
        chunk_sectors_next = '0;
        poll_count_next    = '0;
        push               = 1'b1;
        job.action         = ACT_DONE;
      end else begin
        do_issue = 1'b1;
        iss_left = fin_left;
        iss_lba  = fin_lba;
      end
    end

    if (do_issue) begin
      iss_chunk = (iss_left >= LBA_W'(MAX_CHUNK)) ? CHUNK_W'(MAX_CHUNK)
                : iss_left[CHUNK_W-1:0];
      chunk_sectors_next = iss_chunk;
      expecting_next     = 1'b1;
      poll_count_next    = '0;
      phase_next         = write_mode_next ? PH_POLL : PH_WAIT_RD;
      push               = 1'b1;
      job.cmd            = 1'b1;
      job.sel            = issue_sel;
      job.action         = ACT_REG;
      job.count          = iss_chunk[7:0];
      job.lba            = iss_lba;
      job.dev            = DEV_BASE | DEV_LBA | (drive_bit_next ? DEV_SLAVE : 8'h00);
      job.opcode         = write_mode_next ? CMD_WR : CMD_RD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      write_mode    <= 1'b0;
      drive_bit     <= 1'b0;
      next_lba      <= '0;
      sectors_left  <= '0;
      chunk_sectors <= '0;
      poll_count    <= '0;
      expecting     <= 1'b0;
    end else begin
      phase         <= phase_next;
      write_mode    <= write_mode_next;
      drive_bit     <= drive_bit_next;
      next_lba      <= next_lba_next;
      sectors_left  <= sectors_left_next;
      chunk_sectors <= chunk_sectors_next;
      poll_count    <= poll_count_next;
      expecting     <= expecting_next;
    end
  end

endmodule

[rtl/acps_queue.sv]
module acps_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  acps_pkg::job_t    din,
  input  logic              pop,
  output acps_pkg::job_t    dout,
  output acps_pkg::q_stat_t stat
);
  import acps_pkg::*;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.count = count;
  assign dout       = mem[rd_ptr];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[rtl/acps_back.sv]
module acps_back (
  input  logic                            clk,
  input  logic                            rst,
  input  acps_pkg::job_t                  job,
  input  acps_pkg::q_stat_t               q_stat,
  output logic                            pop,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [acps_pkg::OUT_DATA_W-1:0] out_data,
  output logic [2:0]                      out_user,
  output logic                            out_last
);
  import acps_pkg::*;

  localparam logic [2:0] STEP_LAST = 3'd6;

  logic [2:0]         step, pos;
  logic               emit, last;
  logic [2:0]         r_off;
  logic [7:0]         r_val;
  logic [WORDS_W-1:0] r_words;

  assign emit = !q_stat.empty && (!out_valid || out_ready);
  assign pos  = job.sel ? step : step + 3'd1;
  assign last = !job.cmd || pos == STEP_LAST;
  assign pop  = emit && last;

  always_comb begin
    r_off   = '0;
    r_val   = '0;
    r_words = '0;
    if (job.cmd) begin
      case (pos)
        3'd0: begin r_off = TF_DEVICE; r_val = job.dev; end
        3'd1: begin r_off = TF_COUNT;  r_val = job.count; end
        3'd2: begin r_off = TF_LBA_LO; r_val = job.lba[7:0]; end
        3'd3: begin r_off = TF_LBA_MD; r_val = job.lba[15:8]; end
        3'd4: begin r_off = TF_LBA_HI; r_val = job.lba[23:16]; end
        3'd5: begin r_off = TF_DEVICE; r_val = job.dev | {4'h0, job.lba[27:24]}; end
        3'd6: begin r_off = TF_CMD;    r_val = job.opcode; end
        default: ;
      endcase
    end else begin
      r_words = job.words;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        step      <= last ? 3'd0 : step + 3'd1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold payload while the receiver stalls
  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= OUT_DATA_W'({r_words, r_val, r_off});
      out_user <= job.action;
      out_last <= last;
    end
  end

endmodule

[rtl/ata_pio_command_sequencer.sv]
// Host-side sequencer for ATA PIO LBA28 sector reads and writes.
// Slave stream (s_*): events; tuser carries the event kind (start, drive
// interrupt, status byte, tick, transfer complete), tdata the start
// parameters and status byte. Master stream (m_*): drive actions; tuser is
// the action, tdata the task-file offset, register byte and word count,
// tlast marks the last result of one event.
// Config channel (cfg_*): index 0 highest accepted LBA, index 1 poll limit;
// write only while no event is in flight. cfg_ready is always high.
// The front end takes one event per cycle while the queue has room and
// updates the run state at once, then queues a job (four deep) for the
// back end, which emits one result per cycle while m_tready is high. The
// first result of an event goes through the queue and the output register.
// A start produces seven results and an event that opens the next chunk six;
// other events produce at most one. Events that produce nothing never
// reach the queue. When m_tready stays low the output register holds,
// the queue fills and s_tready drops. Synchronous reset returns the run
// state to idle, empties the queue and loads the default configuration.
`include "assert_macros.svh"

module ata_pio_command_sequencer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // [0] is_write, [1] drive_select, [29:2] first_lba, [57:30] sector_count,
  // [65:58] status_value, [71:66] zero
  input  logic [acps_pkg::IN_DATA_W-1:0]   s_tdata,
  // [2:0] req_type
  input  logic [acps_pkg::TYPE_W-1:0]      s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // [2:0] reg_offset, [10:3] reg_value, [27:11] transfer_words, [31:28] zero
  output logic [acps_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [2:0] action
  output logic [2:0]                       m_tuser,
  output logic                             m_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [acps_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [acps_pkg::LBA_W-1:0]       cfg_data
);
  import acps_pkg::*;

  cfg_t    cfg;
  job_t    push_job, head_job;
  q_stat_t q_stat;
  logic    push, pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.highest_lba <= HIGHEST_LBA_RST;
      cfg.poll_limit  <= POLL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HIGHEST_LBA: cfg.highest_lba <= cfg_data;
        CFG_POLL_LIMIT:  cfg.poll_limit  <= cfg_data[POLL_W-1:0];
        default: ;
      endcase
    end
  end

  acps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_type  (s_tuser),
    .in_data  (s_tdata),
    .q_stat   (q_stat),
    .push     (push),
    .job      (push_job)
  );

  acps_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_job),
    .pop  (pop),
    .dout (head_job),
    .stat (q_stat)
  );

  acps_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser),
    .out_last  (m_tlast)
  );

  `ASSERT_ALWAYS(a_queue_bound, clk, rst, q_stat.count <= QCNT_W'(QUEUE_DEPTH), "queue overfull")
  `ASSERT_IMPLY(a_no_push_full, clk, rst, push, !q_stat.full, "job pushed into full queue")
  `ASSERT_IMPLY(a_no_pop_empty, clk, rst, pop, !q_stat.empty, "job popped from empty queue")

endmodule

[verif/tb.sv]
`timescale 1ns / 100ps

import acps_pkg::*;

typedef enum logic [2:0] {
  SEQ_IDLE,
  SEQ_WAIT_RD,
  SEQ_POLL,
  SEQ_XFER,
  SEQ_WAIT_WR
} seq_phase_e;

// One drive event as it travels on the slave stream.
typedef struct packed {
  logic [2:0]       kind;
  logic             wr;
  logic             drv;
  logic [LBA_W-1:0] lba;
  logic [LBA_W-1:0] cnt;
  logic [7:0]       status;
} drive_event_t;

// One host action as it leaves on the master stream.
typedef struct packed {
  logic [2:0]  action;
  logic [2:0]  offset;
  logic [7:0]  value;
  logic [16:0] words;
  logic        last;
} host_action_t;

class task_file_scoreboard;
  logic [LBA_W-1:0]  highest_lba;
  logic [POLL_W-1:0] poll_limit;

  seq_phase_e        phase;
  logic              write_mode;
  logic              drive_bit;
  logic [LBA_W-1:0]  next_lba;
  logic [LBA_W-1:0]  sectors_left;
  logic [8:0]        chunk_sectors;
  logic [POLL_W-1:0] poll_count;
  logic              irq_armed;

  host_action_t      pending_actions[$];

  int n_events, n_checked, n_errors, n_shown;
  int n_done, n_reject, n_timeout, n_notready, n_xfer;

  function new();
    highest_lba = HIGHEST_LBA_RST;
    poll_limit  = POLL_LIMIT_RST;
    write_mode  = 1'b0;
    drive_bit   = 1'b0;
    next_lba    = '0;
    close_run();
  endfunction

  function void write_config(logic [CFG_IDX_W-1:0] idx, logic [LBA_W-1:0] data);
    if (idx == CFG_HIGHEST_LBA)
      highest_lba = data;
    else if (idx == CFG_POLL_LIMIT)
      poll_limit = data[POLL_W-1:0];
  endfunction

  function void close_run();
    phase         = SEQ_IDLE;
    irq_armed     = 1'b0;
    sectors_left  = '0;
    chunk_sectors = '0;
    poll_count    = '0;
  endfunction

  function void push(logic [2:0] act, logic [2:0] off, logic [7:0] val, logic [16:0] words);
    host_action_t a;
    a.action = act;
    a.offset = off;
    a.value  = val;
    a.words  = words;
    a.last   = 1'b0;
    pending_actions.push_back(a);
    case (act)
      ACT_DONE:     n_done++;
      ACT_REJECT:   n_reject++;
      ACT_TIMEOUT:  n_timeout++;
      ACT_NOTREADY: n_notready++;
      ACT_XFER:     n_xfer++;
      default: ;
    endcase
  endfunction

  function logic [7:0] device_byte();
    return DEV_BASE | DEV_LBA | (drive_bit ? DEV_SLAVE : 8'h00);
  endfunction

  function void issue_command();
    logic [8:0] c;
    c = (sectors_left < LBA_W'(MAX_CHUNK)) ? sectors_left[8:0] : 9'(MAX_CHUNK);
    chunk_sectors = c;
    push(ACT_REG, TF_COUNT,  c[7:0], '0);
    push(ACT_REG, TF_LBA_LO, next_lba[7:0], '0);
    push(ACT_REG, TF_LBA_MD, next_lba[15:8], '0);
    push(ACT_REG, TF_LBA_HI, next_lba[23:16], '0);
    push(ACT_REG, TF_DEVICE, device_byte() | {4'h0, next_lba[27:24]}, '0);
    push(ACT_REG, TF_CMD,    write_mode ? CMD_WR : CMD_RD, '0);
    irq_armed  = 1'b1;
    poll_count = '0;
    phase      = write_mode ? SEQ_POLL : SEQ_WAIT_RD;
  endfunction

  function void retire_chunk();
    next_lba = next_lba + LBA_W'(chunk_sectors);
    sectors_left = (LBA_W'(chunk_sectors) >= sectors_left) ? '0
                 : sectors_left - LBA_W'(chunk_sectors);
    if (sectors_left == '0) begin
      close_run();
      push(ACT_DONE, '0, '0, '0);
    end else begin
      issue_command();
    end
  endfunction

  // Advance the sequencer state for one accepted event and queue the actions
  // it causes. Returns how many actions were queued.
  function int note_event(drive_event_t ev);
    int first;
    first = pending_actions.size();
    n_events++;
    case (ev.kind)
      REQ_START: begin
        if (phase != SEQ_IDLE || ev.cnt == '0 || ev.lba > highest_lba) begin
          push(ACT_REJECT, '0, '0, '0);
        end else begin
          write_mode   = ev.wr;
          drive_bit    = ev.drv;
          next_lba     = ev.lba;
          sectors_left = ev.cnt;
          push(ACT_REG, TF_DEVICE, device_byte(), '0);
          issue_command();
        end
      end
      REQ_IRQ: begin
        if (irq_armed) begin
          if (phase == SEQ_WAIT_RD) begin
            irq_armed  = 1'b0;
            poll_count = 16'd1;
            phase      = SEQ_POLL;
            push(ACT_STATUS, '0, '0, '0);
          end else if (phase == SEQ_WAIT_WR) begin
            irq_armed = 1'b0;
            retire_chunk();
          end
        end
      end
      REQ_STAT: begin
        if (phase == SEQ_POLL && (ev.status & ST_BSY) == 8'h00) begin
          if ((ev.status & ST_DRQ) != 8'h00) begin
            phase = SEQ_XFER;
            push(ACT_XFER, '0, '0, {chunk_sectors, 8'h00});
          end else begin
            close_run();
            push(ACT_NOTREADY, '0, '0, '0);
          end
        end
      end
      REQ_TICK: begin
        if (phase == SEQ_POLL) begin
          if (poll_count >= poll_limit) begin
            close_run();
            push(ACT_TIMEOUT, '0, '0, '0);
          end else begin
            poll_count = poll_count + 16'd1;
            push(ACT_STATUS, '0, '0, '0);
          end
        end
      end
      REQ_XDONE: begin
        if (phase == SEQ_XFER) begin
          if (write_mode)
            phase = SEQ_WAIT_WR;
          else
            retire_chunk();
        end
      end
      default: ;
    endcase
    if (pending_actions.size() > first)
      pending_actions[pending_actions.size()-1].last = 1'b1;
    return pending_actions.size() - first;
  endfunction

  function void check_result(host_action_t got);
    host_action_t want;
    if (pending_actions.size() == 0) begin
      n_errors++;
      if (n_shown++ < 100)
        $display("%0t: unexpected transfer act=%0d off=%0d val=%02h words=%0d last=%0b",
                 $time, got.action, got.offset, got.value, got.words, got.last);
      return;
    end
    want = pending_actions.pop_front();
    n_checked++;
    if (got.action != want.action || got.offset != want.offset ||
        got.value != want.value || got.words != want.words || got.last != want.last) begin
      n_errors++;
      if (n_shown++ < 100)
        $display("%0t: mismatch expected act=%0d off=%0d val=%02h words=%0d last=%0b, actual act=%0d off=%0d val=%02h words=%0d last=%0b",
                 $time, want.action, want.offset, want.value, want.words, want.last,
                 got.action, got.offset, got.value, got.words, got.last);
    end
  endfunction

  function void drop_leftover();
    if (pending_actions.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected actions never arrived, next expected act=%0d off=%0d",
               $time, pending_actions.size(), pending_actions[0].action,
               pending_actions[0].offset);
      pending_actions.delete();
    end
  endfunction

  function int pending();
    return pending_actions.size();
  endfunction
endclass

module tb;

  localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;
  localparam logic [LBA_W-1:0]  LBA_TOP    = 28'hFFFFFFF;
  localparam int                DRAIN_MAX  = 200000;
  localparam int                SETTLE     = 16;
  localparam int                PHASE_ITEMS = 86;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [TYPE_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [2:0]            m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LBA_W-1:0]      cfg_data = '0;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int phase_sent      = 0;

  task_file_scoreboard sb = new();
  host_action_t        seen_action;

  ata_pio_command_sequencer u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      seen_action.action = m_tuser;
      seen_action.offset = m_tdata[2:0];
      seen_action.value  = m_tdata[10:3];
      seen_action.words  = m_tdata[27:11];
      seen_action.last   = m_tlast;
      sb.check_result(seen_action);
    end
  end

  function automatic drive_event_t make_event(logic [2:0] kind, logic wr, logic drv,
                                              logic [LBA_W-1:0] lba, logic [LBA_W-1:0] cnt,
                                              logic [7:0] status);
    drive_event_t ev;
    ev.kind   = kind;
    ev.wr     = wr;
    ev.drv    = drv;
    ev.lba    = lba;
    ev.cnt    = cnt;
    ev.status = status;
    return ev;
  endfunction

  function automatic drive_event_t random_fields(logic [2:0] kind);
    logic [31:0] r0, r1, r2;
    r0 = $urandom;
    r1 = $urandom;
    r2 = $urandom;
    return make_event(kind, r0[28], r0[29], r0[27:0], r1[27:0], r2[7:0]);
  endfunction

  // Pick an event that moves the current run forward most of the time, with
  // some stray and malformed events mixed in.
  function automatic drive_event_t next_event();
    drive_event_t     ev;
    logic [31:0]      r;
    logic [LBA_W-1:0] top;
    int               pick;
    pick = $urandom_range(99);
    r    = $urandom;
    top  = sb.highest_lba;
    if (pick < 8)
      return random_fields(r[2:0]);
    case (sb.phase)
      SEQ_IDLE: begin
        ev   = random_fields(REQ_START);
        pick = $urandom_range(99);
        if (pick < 6) begin
          ev.cnt = '0;
        end else if (pick < 12 && top != LBA_TOP) begin
          ev.lba = (r[27:0] > top) ? r[27:0] : top + 28'd1;
        end else begin
          case ($urandom_range(2))
            0: r = $urandom_range(top);
            1: r = top - LBA_W'($urandom_range(top < 300 ? top : 300));
            default: r = $urandom_range(top < 1000 ? top : 1000);
          endcase
          ev.lba = r[27:0];
          pick = $urandom_range(99);
          if (pick < 70)      r = $urandom_range(4, 1);
          else if (pick < 90) r = $urandom_range(600, 1);
          else                r = $urandom_range(LBA_TOP, 1);
          ev.cnt = r[27:0];
        end
      end
      SEQ_WAIT_RD: ev = random_fields(pick < 85 ? REQ_IRQ : REQ_TICK);
      SEQ_POLL: begin
        if (pick < 30) begin
          ev = random_fields(REQ_TICK);
        end else if (pick < 95) begin
          ev = random_fields(REQ_STAT);
          if (pick < 55)      ev.status = ev.status | ST_BSY;
          else if (pick < 88) ev.status = (ev.status & 8'h7F) | ST_DRQ;
          else                ev.status = ev.status & ~(ST_BSY | ST_DRQ);
        end else begin
          ev = random_fields(REQ_IRQ);
        end
      end
      SEQ_XFER:    ev = random_fields(pick < 88 ? REQ_XDONE : REQ_IRQ);
      default:     ev = random_fields(pick < 88 ? REQ_IRQ : REQ_STAT);
    endcase
    return ev;
  endfunction

  task automatic send_event(input drive_event_t ev);
    s_tvalid <= 1'b1;
    s_tuser  <= ev.kind;
    s_tdata  <= {6'b0, ev.status, ev.cnt, ev.lba, ev.drv, ev.wr};
    do @(posedge clk); while (!s_tready);
    void'(sb.note_event(ev));
    phase_sent++;
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold until every queued action has come out, then let the back end settle.
  task automatic wait_quiet();
    int cycles;
    cycles = 0;
    s_tvalid <= 1'b0;
    while (sb.pending() != 0 && cycles < DRAIN_MAX) begin
      @(posedge clk);
      cycles++;
    end
    sb.drop_leftover();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [LBA_W-1:0] lba_max, input logic [POLL_W-1:0] limit);
    logic [LBA_W-1:0] limit_word;
    logic [31:0]      r;
    r = $urandom;
    limit_word = {r[11:0], limit};
    cfg_valid <= 1'b1;
    cfg_index <= CFG_HIGHEST_LBA;
    cfg_data  <= lba_max;
    do @(posedge clk); while (!cfg_ready);
    sb.write_config(CFG_HIGHEST_LBA, lba_max);
    cfg_index <= CFG_POLL_LIMIT;
    cfg_data  <= limit_word;
    do @(posedge clk); while (!cfg_ready);
    sb.write_config(CFG_POLL_LIMIT, limit_word);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [31:0] r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_config(HIGHEST_LBA_RST, 16'd2);

    // Rejections and stray events while idle.
    send_event(make_event(REQ_START, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_START, 1'b0, 1'b0, HIGHEST_LBA_RST + 28'd1, 28'd1, 8'h00));
    send_event(make_event(REQ_IRQ, 1'b1, 1'b1, LBA_TOP, LBA_TOP, 8'hFF));
    send_event(make_event(REQ_TICK, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_UNUSED, 1'b1, 1'b1, LBA_TOP, LBA_TOP, 8'hFF));

    // Single-sector read from the slave drive at the highest allowed address.
    send_event(make_event(REQ_START, 1'b0, 1'b1, HIGHEST_LBA_RST, 28'd1, 8'h00));
    send_event(make_event(REQ_START, 1'b1, 1'b0, 28'd5, 28'd1, 8'h00));
    send_event(make_event(REQ_TICK, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_IRQ, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_STAT, 1'b0, 1'b0, 28'd0, 28'd0, 8'h88));
    send_event(make_event(REQ_TICK, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_STAT, 1'b0, 1'b0, 28'd0, 28'd0, ST_DRQ));
    send_event(make_event(REQ_XDONE, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));

    // Write of 257 sectors: a full chunk, then one more that times out.
    send_event(make_event(REQ_START, 1'b1, 1'b0, 28'h200FF, 28'd257, 8'h00));
    send_event(make_event(REQ_IRQ, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_STAT, 1'b0, 1'b0, 28'd0, 28'd0, 8'hFF));
    send_event(make_event(REQ_STAT, 1'b0, 1'b0, 28'd0, 28'd0, 8'h7F));
    send_event(make_event(REQ_XDONE, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_IRQ, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_TICK, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_TICK, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_TICK, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));

    // Read that ends with BSY and DRQ both clear.
    send_event(make_event(REQ_START, 1'b0, 1'b1, 28'd0, 28'd5, 8'h00));
    send_event(make_event(REQ_IRQ, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    send_event(make_event(REQ_STAT, 1'b0, 1'b0, 28'd0, 28'd0, 8'h00));
    wait_quiet();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          write_config(LBA_TOP, 16'd1);
        end
        1: begin
          sender_idle_pct = 48;
          recv_stall_pct  = 0;
          write_config(28'd0, 16'hFFFF);
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 48;
          r = $urandom;
          write_config(r[27:0], 16'($urandom_range(6, 2)));
        end
        default: begin
          sender_idle_pct = 14;
          recv_stall_pct  = 14;
          write_config(HIGHEST_LBA_RST, 16'd3);
        end
      endcase
      phase_sent = 0;
      while (phase_sent < PHASE_ITEMS)
        send_event(next_event());
      wait_quiet();
    end

    $display("Covered %0d events in four pacing phases, %0d actions checked, %0d data transfers",
             sb.n_events, sb.n_checked, sb.n_xfer);
    $display("Runs ended: %0d done, %0d rejected starts, %0d timeouts, %0d not ready",
             sb.n_done, sb.n_reject, sb.n_timeout, sb.n_notready);
    if (sb.n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("%0t: timeout, %0d actions still expected", $time, sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
